>>> rtl/core/dss_pkg.sv
package dss_pkg;

  localparam int VOICE_W    = 3;
  localparam int VEL_W      = 16;
  localparam int BYTE_W     = 8;
  localparam int MAX_TRIG   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int MODE_W     = 2;

  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RECORD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ERASE  = 2'd2;

  localparam logic [1:0] EDIT_RECORD = 2'd1;
  localparam logic [1:0] EDIT_ERASE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_EDIT_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEXT_TRACK  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEXT_ENABLE = 2'd3;

  typedef struct packed {
    logic clr_en;
    logic accept;
    logic rd_en;
    logic advance;
    logic emit;
  } dss_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_tick;
    logic rd_last;
    logic any;
    logic out_free;
    logic last_pick;
  } dss_sts_t;

endpackage

>>> rtl/core/dss_ram.sv
module dss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/dss_ctrl.sv
module dss_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  dss_pkg::dss_sts_t sts,
  output dss_pkg::dss_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_SETTLE,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && sts.is_tick) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        if (sts.rd_last) begin
          state_next = S_SETTLE;
        end
      end
      S_SETTLE: begin
        cmd.advance = 1'b1;
        state_next  = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = sts.any && sts.out_free;
        if (!sts.any || (cmd.emit && sts.last_pick)) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

endmodule

>>> rtl/core/dss_datapath.sv
module dss_datapath #(
  parameter int VOICES    = 8,
  parameter int MAX_STEPS = 64,
  parameter int TRACKS    = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  dss_pkg::dss_cmd_t                   cmd,
  output dss_pkg::dss_sts_t                   sts,
  input  logic                                cfg_valid,
  input  logic [dss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dss_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [dss_pkg::MODE_W-1:0]          mode,
  input  logic [dss_pkg::VOICE_W-1:0]         voice,
  input  logic [dss_pkg::VEL_W-1:0]           velocity,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dss_pkg::VOICE_W-1:0]         voice_out,
  output logic [dss_pkg::VEL_W-1:0]           velocity_out,
  output logic                                last
);

  localparam int DEPTH  = TRACKS * MAX_STEPS * VOICES;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW     = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int SW     = $clog2(MAX_STEPS);
  localparam int LEN_W  = (SW + 1 > 8) ? SW + 1 : 8;
  localparam int SCAN   = (VOICES < dss_pkg::MAX_TRIG) ? VOICES : dss_pkg::MAX_TRIG;
  localparam int SIW    = (SCAN > 1) ? $clog2(SCAN) : 1;
  localparam int BW     = dss_pkg::BYTE_W;

  logic [1:0]                    edit_mode;
  logic [dss_pkg::CFG_DATA_W-1:0] step_count;
  logic [1:0]                    next_track;
  logic                          next_track_enable;

  logic [TW-1:0]   active_track;
  logic [SW-1:0]   step_pos;
  logic [AW-1:0]   clr_addr;
  logic [SIW-1:0]  rd_idx;
  logic [SIW-1:0]  rd_slot;
  logic            rd_pend;
  logic [BW-1:0]   vel_buf [SCAN];
  logic [SCAN-1:0] nz;

  logic [AW-1:0]    row_base;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    hit_addr;
  logic [AW-1:0]    waddr;
  logic [BW-1:0]    wdata;
  logic             we;
  logic             hit_we;
  logic [BW-1:0]    rdata;
  logic [SIW-1:0]   sel_idx;
  logic             found;
  logic [SCAN-1:0]  rest;
  logic [LEN_W-1:0] meas_len;
  logic [LEN_W-1:0] step_inc;
  logic             wrap;
  logic             take_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      edit_mode         <= '0;
      step_count        <= dss_pkg::CFG_DATA_W'(16);
      next_track        <= '0;
      next_track_enable <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dss_pkg::REG_EDIT_MODE:   edit_mode         <= cfg_data[1:0];
        dss_pkg::REG_STEP_COUNT:  step_count        <= cfg_data;
        dss_pkg::REG_NEXT_TRACK:  next_track        <= cfg_data[1:0];
        dss_pkg::REG_NEXT_ENABLE: next_track_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign row_base = AW'(AW'(active_track) * AW'(MAX_STEPS)) + AW'(step_pos);
  assign rd_addr  = AW'(row_base * AW'(VOICES)) + AW'(rd_idx);
  assign hit_addr = AW'(row_base * AW'(VOICES)) + AW'(voice);

  assign hit_we = cmd.accept && (int'(voice) < VOICES) &&
                  (((mode == dss_pkg::MODE_RECORD) && (edit_mode == dss_pkg::EDIT_RECORD)) ||
                   ((mode == dss_pkg::MODE_ERASE) && (edit_mode == dss_pkg::EDIT_ERASE)));

  assign we    = cmd.clr_en || hit_we;
  assign waddr = cmd.clr_en ? clr_addr : hit_addr;
  assign wdata = (cmd.clr_en || (mode != dss_pkg::MODE_RECORD)) ? '0 : velocity[15:8];

  dss_ram #(
    .WIDTH (BW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_en) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx  <= '0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.rd_en;
      if (cmd.rd_en) begin
        rd_idx <= sts.rd_last ? '0 : rd_idx + SIW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_slot <= rd_idx;
    if (rd_pend) begin
      vel_buf[rd_slot] <= rdata;
    end
  end

  always_comb begin
    sel_idx = '0;
    found   = 1'b0;
    for (int i = 0; i < SCAN; i++) begin
      if (nz[i] && !found) begin
        sel_idx = SIW'(i);
        found   = 1'b1;
      end
    end
    rest = nz & ~(SCAN'(1) << sel_idx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nz        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rd_pend) begin
        nz[rd_slot] <= (rdata != '0);
      end else if (cmd.emit) begin
        nz <= rest;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      voice_out    <= dss_pkg::VOICE_W'(sel_idx);
      velocity_out <= {vel_buf[sel_idx], 8'h00};
      last         <= (rest == '0);
    end
  end

  always_comb begin
    if (step_count == '0) begin
      meas_len = LEN_W'(1);
    end else if (LEN_W'(step_count) > LEN_W'(MAX_STEPS)) begin
      meas_len = LEN_W'(MAX_STEPS);
    end else begin
      meas_len = LEN_W'(step_count);
    end
  end

  assign step_inc  = LEN_W'(step_pos) + LEN_W'(1);
  assign wrap      = (step_inc >= meas_len);
  assign take_next = next_track_enable && (int'(next_track) < TRACKS) &&
                     (int'(next_track) != int'(active_track));

  always_ff @(posedge clk) begin
    if (rst) begin
      step_pos     <= '0;
      active_track <= '0;
    end else if (cmd.advance) begin
      if (wrap) begin
        step_pos <= '0;
        if (take_next) begin
          active_track <= TW'(next_track);
        end
      end else begin
        step_pos <= SW'(step_inc);
      end
    end
  end

  assign sts.clr_done  = (clr_addr == AW'(DEPTH - 1));
  assign sts.is_tick   = (mode == dss_pkg::MODE_TICK);
  assign sts.rd_last   = (rd_idx == SIW'(SCAN - 1));
  assign sts.any       = |nz;
  assign sts.out_free  = !out_valid || out_ready;
  assign sts.last_pick = (rest == '0);

endmodule

>>> rtl/core/drum_step_sequencer_unit.sv
// Channel   Handshake               Payload
// in        in_valid / in_ready     mode, voice, velocity
// out       out_valid / out_ready   voice_out, velocity_out, last
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Record, erase and unused items are taken without leaving the idle state.
// A tick reads min(VOICES,8) bytes of its step through the store's single read
// port, then loads its trigger beats in voice order (none for a silent tick),
// waiting while out_ready is low; in_ready stays low until the last beat is loaded.
// After reset the store's TRACKS*MAX_STEPS*VOICES bytes (2048 by default) are
// cleared one byte per cycle with in_ready low; cfg writes are taken throughout.
// The output register lets a finished trigger wait while the next item enters.
module drum_step_sequencer_unit #(
  parameter int VOICES    = 8,
  parameter int MAX_STEPS = 64,
  parameter int TRACKS    = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [dss_pkg::MODE_W-1:0]      mode,
  input  logic [dss_pkg::VOICE_W-1:0]     voice,
  input  logic [dss_pkg::VEL_W-1:0]       velocity,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dss_pkg::VOICE_W-1:0]     voice_out,
  output logic [dss_pkg::VEL_W-1:0]       velocity_out,
  output logic                            last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dss_pkg::CFG_DATA_W-1:0]  cfg_data
);

  dss_pkg::dss_cmd_t cmd;
  dss_pkg::dss_sts_t sts;

  assign cfg_ready = 1'b1;

  dss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dss_datapath #(
    .VOICES    (VOICES),
    .MAX_STEPS (MAX_STEPS),
    .TRACKS    (TRACKS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mode         (mode),
    .voice        (voice),
    .velocity     (velocity),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .voice_out    (voice_out),
    .velocity_out (velocity_out),
    .last         (last)
  );

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_en |-> (!in_ready && !out_valid))
    else $error("item or beat during store clear");

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (mode == dss_pkg::MODE_TICK)) |=> !in_ready)
    else $error("new item taken while a tick is being read");

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> ((!out_valid || out_ready) && !in_ready))
    else $error("trigger loaded over a pending beat");

endmodule

>>> test/tb_drum_step_sequencer_unit.sv
`timescale 1ns / 1ps

module tb_drum_step_sequencer_unit;

  localparam int NUM_VOICES   = 8;
  localparam int NUM_STEPS    = 64;
  localparam int NUM_TRACKS   = 4;
  localparam int STALL_LIMIT  = 10000;
  localparam int DRAIN_CYCLES = 24;
  localparam int REPORT_MAX   = 10;

  localparam logic [dss_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0]                 EDIT_PLAY   = 2'd0;
  localparam logic [1:0]                 EDIT_LOCKED = 2'd3;

  typedef struct packed {
    logic [dss_pkg::VOICE_W-1:0] voice;
    logic [dss_pkg::VEL_W-1:0]   vel;
    logic                        last;
  } trigger_t;

  logic                           clk;
  logic                           rst       = 1'b1;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  logic [dss_pkg::MODE_W-1:0]     mode      = dss_pkg::MODE_TICK;
  logic [dss_pkg::VOICE_W-1:0]    voice     = '0;
  logic [dss_pkg::VEL_W-1:0]      velocity  = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [dss_pkg::VOICE_W-1:0]    voice_out;
  logic [dss_pkg::VEL_W-1:0]      velocity_out;
  logic                           trig_last;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [dss_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [dss_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  trigger_t    pending_triggers[$];
  int unsigned n_fail       = 0;
  int unsigned stall_cycles = 0;
  bit          no_idle      = 1'b0;

  logic [dss_pkg::BYTE_W-1:0]     pattern_mem [NUM_TRACKS][NUM_STEPS][NUM_VOICES];
  int unsigned                    play_step;
  int unsigned                    play_track;
  logic [1:0]                     edit_mode_q;
  logic [dss_pkg::CFG_DATA_W-1:0] step_count_q;
  logic [1:0]                     next_track_q;
  logic                           next_enable_q;

  drum_step_sequencer_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .voice        (voice),
    .velocity     (velocity),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .voice_out    (voice_out),
    .velocity_out (velocity_out),
    .last         (trig_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_wait();
    if (no_idle || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  function automatic void predict_item(input logic [dss_pkg::MODE_W-1:0] m,
                                       input logic [dss_pkg::VOICE_W-1:0] v,
                                       input logic [dss_pkg::VEL_W-1:0] vel);
    int unsigned len;
    int          n;
    trigger_t    t;
    n = 0;
    if (m == dss_pkg::MODE_RECORD) begin
      if (edit_mode_q == dss_pkg::EDIT_RECORD)
        pattern_mem[play_track][play_step][v] = vel[15:8];
    end else if (m == dss_pkg::MODE_ERASE) begin
      if (edit_mode_q == dss_pkg::EDIT_ERASE)
        pattern_mem[play_track][play_step][v] = '0;
    end else if (m == dss_pkg::MODE_TICK) begin
      for (int r = 0; r < NUM_VOICES; r++) begin
        if (pattern_mem[play_track][play_step][r] != 0) begin
          t.voice = dss_pkg::VOICE_W'(r);
          t.vel   = {pattern_mem[play_track][play_step][r], 8'h00};
          t.last  = 1'b0;
          pending_triggers.push_back(t);
          n++;
        end
      end
      if (n > 0) pending_triggers[pending_triggers.size() - 1].last = 1'b1;
      len = (step_count_q == 0) ? 1 : (step_count_q > NUM_STEPS) ? NUM_STEPS : step_count_q;
      play_step++;
      if (play_step >= len) begin
        if (next_enable_q && next_track_q < NUM_TRACKS && next_track_q != play_track)
          play_track = next_track_q;
        play_step = 0;
      end
    end
  endfunction

  task automatic send_item(input logic [dss_pkg::MODE_W-1:0] m,
                           input logic [dss_pkg::VOICE_W-1:0] v,
                           input logic [dss_pkg::VEL_W-1:0] vel);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    voice    <= v;
    velocity <= vel;
    do @(posedge clk); while (!in_ready);
    predict_item(m, v, vel);
  endtask

  task automatic write_reg(input logic [dss_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dss_pkg::CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    while (pending_triggers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      dss_pkg::REG_EDIT_MODE:   edit_mode_q   = data[1:0];
      dss_pkg::REG_STEP_COUNT:  step_count_q  = data;
      dss_pkg::REG_NEXT_TRACK:  next_track_q  = data[1:0];
      dss_pkg::REG_NEXT_ENABLE: next_enable_q = data[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_idle_items();
    send_item(dss_pkg::MODE_TICK, 3'd0, 16'h0000);
    send_item(MODE_UNUSED, 3'd7, 16'hFFFF);
    send_item(dss_pkg::MODE_RECORD, 3'd7, 16'hFFFF);
  endtask

  task automatic test_record_playback();
    logic [dss_pkg::VEL_W-1:0] hit_vel [NUM_VOICES];
    hit_vel = '{16'hFFFF, 16'h0100, 16'h8000, 16'h00FF,
                16'h7F00, 16'h5A5A, 16'hA5A5, 16'h01FF};
    write_reg(dss_pkg::REG_EDIT_MODE, 7'(dss_pkg::EDIT_RECORD));
    write_reg(dss_pkg::REG_STEP_COUNT, 7'd1);
    for (int v = 0; v < NUM_VOICES; v++)
      send_item(dss_pkg::MODE_RECORD, dss_pkg::VOICE_W'(v), hit_vel[v]);
    send_item(dss_pkg::MODE_TICK, 3'd5, 16'h0000);
    send_item(dss_pkg::MODE_RECORD, 3'd4, 16'h1234);
    send_item(dss_pkg::MODE_TICK, 3'd0, 16'hFFFF);
  endtask

  task automatic test_erase();
    write_reg(dss_pkg::REG_EDIT_MODE, 7'(dss_pkg::EDIT_ERASE));
    write_reg(dss_pkg::REG_STEP_COUNT, 7'd3);
    send_item(dss_pkg::MODE_ERASE, 3'd4, 16'h0000);
    send_item(dss_pkg::MODE_RECORD, 3'd1, 16'hFFFF);
    send_item(dss_pkg::MODE_TICK, 3'd0, 16'h0000);
    send_item(dss_pkg::MODE_ERASE, 3'd7, 16'hFFFF);
    send_item(dss_pkg::MODE_TICK, 3'd0, 16'h0000);
    send_item(dss_pkg::MODE_TICK, 3'd0, 16'h0000);
  endtask

  task automatic test_locked_edit();
    write_reg(dss_pkg::REG_EDIT_MODE, 7'(EDIT_LOCKED));
    send_item(dss_pkg::MODE_TICK, 3'd0, 16'h0000);
    send_item(dss_pkg::MODE_RECORD, 3'd3, 16'hFFFF);
    send_item(dss_pkg::MODE_ERASE, 3'd0, 16'h0000);
    send_item(dss_pkg::MODE_TICK, 3'd0, 16'h0000);
  endtask

  task automatic test_measure_limits();
    write_reg(dss_pkg::REG_STEP_COUNT, 7'd0);
    send_item(dss_pkg::MODE_TICK, 3'd0, 16'h0000);
    send_item(dss_pkg::MODE_TICK, 3'd0, 16'h0000);
    write_reg(dss_pkg::REG_STEP_COUNT, 7'd127);
    send_item(dss_pkg::MODE_TICK, 3'd0, 16'h0000);
    send_item(dss_pkg::MODE_TICK, 3'd0, 16'h0000);
    write_reg(dss_pkg::REG_STEP_COUNT, 7'd64);
  endtask

  task automatic test_track_switch();
    write_reg(dss_pkg::REG_STEP_COUNT, 7'd1);
    write_reg(dss_pkg::REG_NEXT_TRACK, 7'h7E);
    write_reg(dss_pkg::REG_NEXT_ENABLE, 7'h01);
    send_item(dss_pkg::MODE_TICK, 3'd0, 16'h0000);
    send_item(dss_pkg::MODE_TICK, 3'd0, 16'h0000);
    write_reg(dss_pkg::REG_NEXT_ENABLE, 7'h7E);
    write_reg(dss_pkg::REG_NEXT_TRACK, 7'h03);
    send_item(dss_pkg::MODE_TICK, 3'd0, 16'h0000);
  endtask

  task automatic random_item();
    int                         pick;
    logic [dss_pkg::MODE_W-1:0] m;
    logic [dss_pkg::VEL_W-1:0]  vel;
    pick = $urandom_range(0, 99);
    case (edit_mode_q)
      dss_pkg::EDIT_RECORD: m = pick < 50 ? dss_pkg::MODE_RECORD :
                                pick < 95 ? dss_pkg::MODE_TICK :
                                pick < 98 ? dss_pkg::MODE_ERASE : MODE_UNUSED;
      dss_pkg::EDIT_ERASE:  m = pick < 30 ? dss_pkg::MODE_ERASE :
                                pick < 90 ? dss_pkg::MODE_TICK :
                                pick < 96 ? dss_pkg::MODE_RECORD : MODE_UNUSED;
      default:              m = pick < 75 ? dss_pkg::MODE_TICK :
                                pick < 85 ? dss_pkg::MODE_RECORD :
                                pick < 95 ? dss_pkg::MODE_ERASE : MODE_UNUSED;
    endcase
    if ($urandom_range(0, 7) == 0) vel = dss_pkg::VEL_W'($urandom_range(0, 255));
    else vel = dss_pkg::VEL_W'($urandom());
    send_item(m, dss_pkg::VOICE_W'($urandom_range(0, NUM_VOICES - 1)), vel);
  endtask

  task automatic test_random_phases();
    int                             pick;
    logic [1:0]                     edit;
    logic [dss_pkg::CFG_DATA_W-1:0] len;
    for (int p = 0; p < 10; p++) begin
      pick = $urandom_range(0, 9);
      edit = pick < 5 ? dss_pkg::EDIT_RECORD : pick < 7 ? dss_pkg::EDIT_ERASE :
             pick < 9 ? EDIT_PLAY : EDIT_LOCKED;
      pick = $urandom_range(0, 19);
      len  = pick == 0 ? 7'd0 : pick == 1 ? 7'd64 :
             pick == 2 ? 7'($urandom_range(65, 127)) : 7'($urandom_range(1, 8));
      write_reg(dss_pkg::REG_EDIT_MODE, {5'($urandom()), edit});
      write_reg(dss_pkg::REG_STEP_COUNT, len);
      write_reg(dss_pkg::REG_NEXT_TRACK, {5'($urandom()), 2'($urandom())});
      write_reg(dss_pkg::REG_NEXT_ENABLE, {6'($urandom()), 1'($urandom())});
      no_idle = (p % 3 == 2);
      repeat (42) random_item();
    end
    no_idle = 1'b0;
  endtask

  initial begin : trigger_sink
    int stall;
    wait (!rst);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : check_triggers
    trigger_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_triggers.size() == 0) begin
        if (n_fail < REPORT_MAX)
          $display("unexpected trigger: voice %0d vel %h last %0b",
                   voice_out, velocity_out, trig_last);
        n_fail++;
      end else begin
        want = pending_triggers.pop_front();
        if (want.voice !== voice_out || want.vel !== velocity_out ||
            want.last !== trig_last) begin
          if (n_fail < REPORT_MAX)
            $display("trigger mismatch: expected voice %0d vel %h last %0b,",
                     want.voice, want.vel, want.last,
                     " got voice %0d vel %h last %0b",
                     voice_out, velocity_out, trig_last);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    foreach (pattern_mem[t, s, v]) pattern_mem[t][s][v] = '0;
    play_step     = 0;
    play_track    = 0;
    edit_mode_q   = EDIT_PLAY;
    step_count_q  = 7'd16;
    next_track_q  = 2'd0;
    next_enable_q = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_idle_items();
    test_record_playback();
    test_erase();
    test_locked_edit();
    test_measure_limits();
    test_track_switch();
    test_random_phases();
    in_valid <= 1'b0;
    while (pending_triggers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

>>> drum_step_sequencer_unit.f
rtl/core/dss_pkg.sv
rtl/core/dss_ram.sv
rtl/core/dss_ctrl.sv
rtl/core/dss_datapath.sv
rtl/core/drum_step_sequencer_unit.sv
test/tb_drum_step_sequencer_unit.sv
